// File: rtl/unsigned_to_decimal_digits_macros.svh
// ---------------------------------------------------------------------------
// unsigned_to_decimal_digits assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef UNSIGNED_TO_DECIMAL_DIGITS_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_DIGITS_MACROS_SVH

// same-cycle implication, disabled in reset
`define UTDD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define UTDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// condition that must never hold
`define UTDD_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");

`endif

// File: rtl/utdd_pkg.sv
// ---------------------------------------------------------------------------
// utdd_pkg
// widths, counts and control types for the decimal digit converter
// ---------------------------------------------------------------------------
package utdd_pkg;

  // width of the binary input value
  localparam int VALUE_BITS = 32;

  // decimal digits of the largest value: floor(bits * log10(2)) + 1
  localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

  localparam int CNT_BITS = $clog2(NUM_DIGITS + 1);
  localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);
  localparam int S_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  localparam int CHAR_BITS = 6;
  localparam int COUNT_BITS = 4;
  localparam int M_DATA_BITS = ((CHAR_BITS + COUNT_BITS + 7) / 8) * 8;

  localparam int DIGIT_BITS = 4;

  // ascii '0' is 6'b110000, so a digit below ten just fills the low nibble
  localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

  typedef logic [DIGIT_BITS-1:0] digit_t;

  // control from the sequencer to the bcd register
  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift_digit;
    logic in_bit;
  } bcd_ctrl_t;

endpackage

// File: rtl/utdd_bcd_reg.sv
// ---------------------------------------------------------------------------
// utdd_bcd_reg
// bcd digit register: shift-and-add-3 step, digit shift-out
// ---------------------------------------------------------------------------
module utdd_bcd_reg (
  input  logic                clk,
  input  utdd_pkg::bcd_ctrl_t ctrl,
  output utdd_pkg::digit_t    top_digit
);

  utdd_pkg::digit_t [utdd_pkg::NUM_DIGITS-1:0] bcd;
  utdd_pkg::digit_t [utdd_pkg::NUM_DIGITS-1:0] adj;
  logic [utdd_pkg::NUM_DIGITS*utdd_pkg::DIGIT_BITS-1:0] flat;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < utdd_pkg::NUM_DIGITS; i++) begin
      if (bcd[i] >= utdd_pkg::digit_t'(5)) begin
        adj[i] = bcd[i] + utdd_pkg::digit_t'(3);
      end else begin
        adj[i] = bcd[i];
      end
    end
    flat = adj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      bcd <= '0;
    end else if (ctrl.dabble) begin
      bcd <= {flat[utdd_pkg::NUM_DIGITS*utdd_pkg::DIGIT_BITS-2:0], ctrl.in_bit};
    end else if (ctrl.shift_digit) begin
      bcd <= {bcd[utdd_pkg::NUM_DIGITS-2:0], utdd_pkg::digit_t'(0)};
    end
  end

  assign top_digit = bcd[utdd_pkg::NUM_DIGITS-1];

endmodule

// File: rtl/unsigned_to_decimal_digits.sv
// ---------------------------------------------------------------------------
// unsigned_to_decimal_digits
// unsigned binary to ascii decimal digits, most significant first
// ---------------------------------------------------------------------------
// usage:
//   s_* channel takes one value per transaction in s_tdata.
//   m_* channel returns one transaction per decimal digit, most significant
//   first, with no leading zeros; m_tlast marks the final digit of a number.
//   zero gives the single digit '0' with a count of one.
// timing:
//   the value is shifted bit-serially through a shift-and-add-3 bcd
//   register, one bit per cycle, then leading zero digits are dropped
//   one per cycle, then digits leave one per cycle while m_tready is high.
//   one item is in work at a time; s_tready is high only while idle.
// reset:
//   rst (synchronous) returns the sequencer to idle and drops m_tvalid.
// stall:
//   with m_tready low the current digit holds on m_tdata/m_tlast and the
//   sequencer waits; nothing is lost.
// ---------------------------------------------------------------------------
module unsigned_to_decimal_digits (
  input  logic                               clk,
  input  logic                               rst,
  // input value channel
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [utdd_pkg::S_DATA_BITS-1:0]   s_tdata,   // value
  // output digit channel
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [utdd_pkg::M_DATA_BITS-1:0]   m_tdata,   // digit_char, digit_count
  output logic                               m_tlast    // last_digit
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_TRIM = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // binary shift register, msb leaves first
  logic [utdd_pkg::VALUE_BITS-1:0] bin;
  logic [utdd_pkg::BIT_CNT_BITS-1:0] bit_cnt;

  // total digits and digits still to send
  logic [utdd_pkg::CNT_BITS-1:0] count;
  logic [utdd_pkg::CNT_BITS-1:0] remain;

  utdd_pkg::bcd_ctrl_t bcd_ctrl;
  utdd_pkg::digit_t    top_digit;

  logic s_hs;
  logic m_hs;
  logic drop_zero;
  logic [utdd_pkg::CNT_BITS+utdd_pkg::COUNT_BITS-1:0] count_ext;

  assign s_tready = (state == ST_IDLE);
  assign s_hs     = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_EMIT);
  assign m_hs     = m_tvalid && m_tready;

  // leading zero while more than one digit is left
  assign drop_zero = (top_digit == utdd_pkg::digit_t'(0)) &&
                     (count > utdd_pkg::CNT_BITS'(1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_hs) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt == '0) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (!drop_zero) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_hs && (remain == utdd_pkg::CNT_BITS'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    bcd_ctrl.clear       = s_hs;
    bcd_ctrl.dabble      = (state == ST_CONV);
    bcd_ctrl.in_bit      = bin[utdd_pkg::VALUE_BITS-1];
    bcd_ctrl.shift_digit = ((state == ST_TRIM) && drop_zero) ||
                           (m_hs && (remain != utdd_pkg::CNT_BITS'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // payload and counters, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        bin     <= s_tdata[utdd_pkg::VALUE_BITS-1:0];
        bit_cnt <= utdd_pkg::BIT_CNT_BITS'(utdd_pkg::VALUE_BITS - 1);
        count   <= utdd_pkg::CNT_BITS'(utdd_pkg::NUM_DIGITS);
      end
      ST_CONV: begin
        bin     <= {bin[utdd_pkg::VALUE_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt - utdd_pkg::BIT_CNT_BITS'(1);
      end
      ST_TRIM: begin
        if (drop_zero) begin
          count <= count - utdd_pkg::CNT_BITS'(1);
        end else begin
          remain <= count;
        end
      end
      ST_EMIT: begin
        if (m_hs) begin
          remain <= remain - utdd_pkg::CNT_BITS'(1);
        end
      end
      default: begin
        bin <= bin;
      end
    endcase
  end

  utdd_bcd_reg u_bcd (
    .clk       (clk),
    .ctrl      (bcd_ctrl),
    .top_digit (top_digit)
  );

  // digit count keeps its low four bits
  assign count_ext = {{utdd_pkg::COUNT_BITS{1'b0}}, count};

  assign m_tdata = utdd_pkg::M_DATA_BITS'({count_ext[utdd_pkg::COUNT_BITS-1:0],
                                           utdd_pkg::ASCII_ZERO_HI, top_digit});
  assign m_tlast = (remain == utdd_pkg::CNT_BITS'(1));

endmodule

// File: rtl/utdd_checker.sv
// ---------------------------------------------------------------------------
// utdd_checker
// port-level checks for unsigned_to_decimal_digits
// ---------------------------------------------------------------------------
`include "unsigned_to_decimal_digits_macros.svh"

module utdd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [utdd_pkg::S_DATA_BITS-1:0] s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [utdd_pkg::M_DATA_BITS-1:0] m_tdata,
  input logic                             m_tlast
);

  // stalled digit holds
  `UTDD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // every digit is an ascii decimal character
  `UTDD_ASSERT_IMPL(a_ascii, m_tvalid, (m_tdata[5:0] >= 6'd48) && (m_tdata[5:0] <= 6'd57))

  // no new value taken while a digit run is being sent
  `UTDD_ASSERT_NEVER(a_one_item, s_tready && m_tvalid)

  // digits of one number follow with no gap
  `UTDD_ASSERT_NEXT(a_run, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

bind unsigned_to_decimal_digits utdd_checker u_utdd_checker (.*);

// File: tb/unsigned_to_decimal_digits_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unsigned_to_decimal_digits_checker
// watches both stream channels, predicts the digit run of every accepted
// value and compares each digit transaction with the oldest prediction
// ---------------------------------------------------------------------------
module unsigned_to_decimal_digits_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [utdd_pkg::S_DATA_BITS-1:0]   s_tdata,   // value
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [utdd_pkg::M_DATA_BITS-1:0]   m_tdata,   // digit_char, digit_count
  input  logic                               m_tlast,   // last_digit
  output int                                 fail_count,
  output int                                 pending,
  output int                                 values_seen,
  output int                                 digits_seen
);
  import utdd_pkg::*;

  localparam int          RADIX      = 10;
  localparam int          MAX_RUN    = 20;
  localparam int          PAD_BITS   = M_DATA_BITS - CHAR_BITS - COUNT_BITS;
  localparam logic [5:0]  CHAR_ZERO  = 6'd48;

  typedef struct packed {
    logic [CHAR_BITS-1:0]  chr;
    logic                  last;
    logic [COUNT_BITS-1:0] count;
  } digit_rec_t;

  digit_rec_t digits_due[$];

  // decimal run of one value, most significant digit first
  function automatic void queue_decimal_run(input logic [VALUE_BITS-1:0] value);
    logic [3:0]            rev [MAX_RUN];
    logic [VALUE_BITS-1:0] rest;
    int                    n;
    digit_rec_t            rec;
    rest = value;
    n = 0;
    do begin
      rev[n] = 4'(rest % RADIX);
      rest = rest / RADIX;
      n++;
    end while (rest != 0 && n < MAX_RUN);
    for (int k = 0; k < n; k++) begin
      rec.chr   = CHAR_ZERO + CHAR_BITS'(rev[n-1-k]);
      rec.last  = (k == n - 1);
      rec.count = COUNT_BITS'(n);
      digits_due.push_back(rec);
    end
  endfunction

  initial begin
    fail_count  = 0;
    pending     = 0;
    values_seen = 0;
    digits_seen = 0;
  end

  always @(posedge clk) begin
    digit_rec_t want;
    logic [CHAR_BITS-1:0]  got_chr;
    logic [COUNT_BITS-1:0] got_count;
    logic [PAD_BITS-1:0]   got_pad;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        queue_decimal_run(s_tdata[VALUE_BITS-1:0]);
        values_seen++;
      end
      if (m_tvalid && m_tready) begin
        digits_seen++;
        got_chr   = m_tdata[CHAR_BITS-1:0];
        got_count = m_tdata[CHAR_BITS +: COUNT_BITS];
        got_pad   = m_tdata[M_DATA_BITS-1 -: PAD_BITS];
        if (digits_due.size() == 0) begin
          $error("digit transaction with no digit pending: char %0d last %0b count %0d",
                 got_chr, m_tlast, got_count);
          fail_count++;
        end else begin
          want = digits_due.pop_front();
          if (got_chr !== want.chr) begin
            $error("digit_char: expected %0d, got %0d", want.chr, got_chr);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_digit: expected %0b, got %0b", want.last, m_tlast);
            fail_count++;
          end
          if (got_count !== want.count) begin
            $error("digit_count: expected %0d, got %0d", want.count, got_count);
            fail_count++;
          end
          if (got_pad !== '0) begin
            $error("m_tdata padding: expected 0, got %0h", got_pad);
            fail_count++;
          end
        end
      end
    end
    // digits predicted but not yet seen
    pending = digits_due.size();
  end

endmodule

// File: tb/unsigned_to_decimal_digits_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unsigned_to_decimal_digits_tb
// drives values into the decimal digit converter through directed edge
// values and random values of every length, under four flow-control phases;
// the checker beside the block predicts and compares every digit
// ---------------------------------------------------------------------------
module unsigned_to_decimal_digits_tb;
  import utdd_pkg::*;

  localparam int ITEMS_PER_PHASE = 120;
  // allow a margin for trailing digits
  localparam int SETTLE_CYCLES   = 60;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [S_DATA_BITS-1:0]   s_tdata;    // value
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [M_DATA_BITS-1:0]   m_tdata;    // digit_char, digit_count
  logic                     m_tlast;    // last_digit

  int fail_count;
  int pending;
  int values_seen;
  int digits_seen;

  // chance in a hundred that a cycle idles on each side
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int directed_sent  = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unsigned_to_decimal_digits uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  unsigned_to_decimal_digits_checker digit_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .pending     (pending),
    .values_seen (values_seen),
    .digits_seen (digits_seen)
  );

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one value transaction; tvalid stays high into the next call so that
  // back-to-back values need no gap
  task automatic send_value(input logic [VALUE_BITS-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = S_DATA_BITS'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = S_DATA_BITS'(value);
    do @(posedge clk); while (!s_tready);
  endtask

  // sender holds off until every predicted digit has come out
  task automatic drain_digits();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // random value: full range, a chosen digit length, or a chosen bit length
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int              sel;
    int              len;
    longint unsigned lo;
    longint unsigned hi;
    logic [31:0]     raw;
    sel = $urandom_range(9);
    if (sel < 4) begin
      return VALUE_BITS'($urandom);
    end else if (sel < 8) begin
      len = $urandom_range(10, 1);
      lo = 1;
      repeat (len - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      return VALUE_BITS'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
    end else begin
      len = $urandom_range(VALUE_BITS, 1);
      raw = $urandom;
      raw = (raw >> (32 - len)) | (32'd1 << (len - 1));
      return VALUE_BITS'(raw);
    end
  endfunction

  initial begin
    longint unsigned p10;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: zero, each power of ten and the value just below it,
    // all ones, top bit alone and alternating patterns
    send_value('0);
    p10 = 1;
    for (int p = 0; p <= 9; p++) begin
      if (p > 0) send_value(VALUE_BITS'(p10 - 1));
      send_value(VALUE_BITS'(p10));
      p10 = p10 * 10;
    end
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h5555_5555);
    send_value(32'hAAAA_AAAA);
    directed_sent = 24;

    // phase 1: no idling on either side
    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(pick_value());
    drain_digits();

    // phase 2: sender idles often
    send_idle_pct = 77;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(pick_value());
    drain_digits();

    // phase 3: receiver stalls often
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(pick_value());
    drain_digits();

    // phase 4: light idling on both sides
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(pick_value());

    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending != 0) $error("%0d predicted digits never came out", pending);
    $display("converted %0d values (%0d directed edge values) across four flow-control phases",
             values_seen, directed_sent);
    $display("compared %0d digit transactions, %0d mismatches", digits_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
